>>> hdl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int MOD_BITS  = 31;
  localparam int EXP_BITS  = 63;
  localparam int BASE_BITS = 63;
  localparam int PROD_BITS = 2 * MOD_BITS;
  // The reducer takes either the raw base or a full product.
  localparam int RED_BITS  = (BASE_BITS > PROD_BITS) ? BASE_BITS : PROD_BITS;
  localparam int CNT_BITS  = $clog2(RED_BITS);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

  typedef struct packed {
    logic load;       // capture operands, start base reduction
    logic wr_base;    // reduced base becomes the first square
    logic start_acc;  // reduce acc * sq
    logic start_sq;   // reduce sq * sq
    logic wr_acc;     // take remainder into acc
    logic wr_sq;      // take remainder into sq, advance exponent
    logic load_out;   // copy acc into the output register
  } mexp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic exp_zero;
    logic exp_bit0;
    logic exp_rest_nz;
  } mexp_sts_t;

endpackage

>>> hdl/mexp_red.sv
`timescale 1ns / 1ps

module mexp_red
  import mexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RED_BITS-1:0] dividend_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  output logic                done_o,
  output logic [MOD_BITS-1:0] rem_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [RED_BITS-1:0] div_q, div_d;
  logic [MOD_BITS-1:0] rem_q, rem_d;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;
  logic                fits;

  // Restoring remainder, one dividend bit per cycle.
  assign trial = {rem_q, div_q[RED_BITS-1]};
  assign diff  = trial - {1'b0, modulus_i};
  assign fits  = (trial >= {1'b0, modulus_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(RED_BITS - 1);
      div_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
      div_d = div_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hdl/mexp_dp.sv
`timescale 1ns / 1ps

module mexp_dp
  import mexp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mexp_cmd_t            cmd_i,
  input  logic [BASE_BITS-1:0] base_value_i,
  input  logic [EXP_BITS-1:0]  exponent_i,
  input  logic [MOD_BITS-1:0]  modulus_i,
  output mexp_sts_t            sts_o,
  output logic [MOD_BITS-1:0]  power_result_o
);

  logic [MOD_BITS-1:0]  acc_q, sq_q, result_q;
  logic [EXP_BITS-1:0]  exp_q;
  logic [MOD_BITS-1:0]  mul_a;
  logic [PROD_BITS-1:0] product;
  logic [RED_BITS-1:0]  red_dividend;
  logic                 red_start;
  logic                 red_done;
  logic [MOD_BITS-1:0]  red_rem;

  assign mul_a   = cmd_i.start_acc ? acc_q : sq_q;
  assign product = {{MOD_BITS{1'b0}}, mul_a} * {{MOD_BITS{1'b0}}, sq_q};

  assign red_dividend = cmd_i.load ? RED_BITS'(base_value_i) : RED_BITS'(product);
  assign red_start    = cmd_i.load | cmd_i.start_acc | cmd_i.start_sq;

  mexp_red u_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (red_start),
    .dividend_i (red_dividend),
    .modulus_i  (modulus_i),
    .done_o     (red_done),
    .rem_o      (red_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= MOD_BITS'(1);
      exp_q <= exponent_i;
    end
    if (cmd_i.wr_base) begin
      sq_q <= red_rem;
    end
    if (cmd_i.wr_acc) begin
      acc_q <= red_rem;
    end
    if (cmd_i.wr_sq) begin
      sq_q  <= red_rem;
      exp_q <= exp_q >> 1;
    end
    if (cmd_i.load_out) begin
      result_q <= acc_q;
    end
  end

  assign sts_o.red_done    = red_done;
  assign sts_o.exp_zero    = (exp_q == '0);
  assign sts_o.exp_bit0    = exp_q[0];
  assign sts_o.exp_rest_nz = ((exp_q >> 1) != '0);

  assign power_result_o = result_q;

endmodule

>>> hdl/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  mexp_sts_t sts_i,
  output mexp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_CHECK,
    ST_RED_ACC,
    ST_RED_SQ,
    ST_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  mexp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_BASE;
        end
      end
      ST_BASE: begin
        if (sts_i.red_done) begin
          cmd.wr_base = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = ST_DONE;
        end else if (sts_i.exp_bit0) begin
          cmd.start_acc = 1'b1;
          state_d       = ST_RED_ACC;
        end else begin
          cmd.start_sq = 1'b1;
          state_d      = ST_RED_SQ;
        end
      end
      ST_RED_ACC: begin
        if (sts_i.red_done) begin
          cmd.wr_acc = 1'b1;
          // skip the final square once no higher bit remains
          if (sts_i.exp_rest_nz) begin
            cmd.start_sq = 1'b1;
            state_d      = ST_RED_SQ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RED_SQ: begin
        if (sts_i.red_done) begin
          cmd.wr_sq = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || cmd.load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> hdl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------
// in       | input     | in_valid_i / in_stall_o   | base_value_i[62:0], exponent_i[62:0]
// out      | output    | out_valid_o / out_stall_i | power_result_o[30:0]
// cfg      | input     | cfg_we_i                  | cfg_wdata_i[30:0] (modulus)
//
// Flow: one item at a time; every reduction runs on one radix-2 remainder unit.
// An exponent of bit length L with w set bits takes L + w reductions, the base one
// included; a zero exponent takes the base reduction alone.
// Reset: asynchronous, active low; modulus returns to 1000000007, no item held.
// Stalls: the output register holds a finished result while the next item is
// accepted and worked on; only a second finished result waits for it.

module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BASE_BITS-1:0] base_value_i,
  input  logic [EXP_BITS-1:0]  exponent_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MOD_BITS-1:0]  power_result_o,
  input  logic                 cfg_we_i,
  input  logic [MOD_BITS-1:0]  cfg_wdata_i
);

  logic [MOD_BITS-1:0] modulus_q;
  logic [MOD_BITS-1:0] modulus_eff;
  mexp_cmd_t           cmd;
  mexp_sts_t           sts;

  // Modulus register; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // A zero modulus behaves as a modulus of one.
  assign modulus_eff = (modulus_q == '0) ? MOD_BITS'(1) : modulus_q;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .modulus_i      (modulus_eff),
    .sts_o          (sts),
    .power_result_o (power_result_o)
  );

  // An accepted item always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after input transfer");

  // A presented result is reduced, or is the unreduced one of a zero exponent.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((power_result_o < modulus_eff) || (power_result_o == MOD_BITS'(1))))
    else $error("result not reduced by modulus");

  // After an output transfer a new result only appears with the block idle.
  a_out_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o || !in_stall_o))
    else $error("output refilled while still busy");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mexp_pkg::*;

  localparam int CLK_HALF_NS  = 2;
  localparam int RESET_CYCLES = 12;
  // Cycles with no transfer before the run is stopped as hung; well above the longest item.
  localparam int QUIET_LIMIT  = 50000;
  // Let the block settle after its last result before touching the modulus.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 200;
  localparam int BLOCK_ITEMS   = 45;

  localparam logic [BASE_BITS-1:0] ALL63   = '1;
  localparam logic [BASE_BITS-1:0] TOP63   = BASE_BITS'(1) << (BASE_BITS - 1);
  localparam logic [BASE_BITS-1:0] ALT_A   = ALL63 / 3;
  localparam logic [BASE_BITS-1:0] ALT_B   = ALL63 ^ ALT_A;
  localparam logic [MOD_BITS-1:0]  MOD_MAX = '1;

  // One directed transfer: modulus in force, operands, and the result where
  // it is obvious by hand (otherwise the predictor supplies it).
  typedef struct packed {
    logic [MOD_BITS-1:0]  modulus;
    logic [BASE_BITS-1:0] base;
    logic [EXP_BITS-1:0]  expo;
    logic                 known;
    logic [MOD_BITS-1:0]  want;
  } row_t;

  localparam int NUM_ROWS = 19;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // reset modulus: zero exponent, small powers, widest operands
    '{MODULUS_RESET, 63'd0,  63'd0,  1'b1, 31'd1},
    '{MODULUS_RESET, 63'd2,  63'd10, 1'b1, 31'd1024},
    '{MODULUS_RESET, ALL63,  63'd0,  1'b1, 31'd1},
    '{MODULUS_RESET, 63'd0,  63'd5,  1'b1, 31'd0},
    '{MODULUS_RESET, ALL63,  ALL63,  1'b0, 31'd0},
    '{MODULUS_RESET, 63'd1,  ALL63,  1'b1, 31'd1},
    // modulus of one: zero exponent still gives one, anything else zero
    '{31'd1,         63'd5,  63'd0,  1'b1, 31'd1},
    '{31'd1,         63'd5,  63'd3,  1'b1, 31'd0},
    '{31'd1,         ALL63,  ALL63,  1'b1, 31'd0},
    // modulus of zero behaves as one
    '{31'd0,         63'd7,  63'd0,  1'b1, 31'd1},
    '{31'd0,         63'd7,  63'd9,  1'b1, 31'd0},
    // largest modulus
    '{MOD_MAX,       ALL63,  ALL63,  1'b0, 31'd0},
    '{MOD_MAX,       63'h7FFF_FFFF, 63'd1, 1'b1, 31'd0},
    '{MOD_MAX,       63'h7FFF_FFFE, 63'd2, 1'b1, 31'd1},
    // tiny moduli, top exponent bit alone
    '{31'd2,         63'd3,  TOP63,  1'b1, 31'd1},
    '{31'd2,         63'd4,  63'd1,  1'b1, 31'd0},
    '{31'd13,        63'd2,  63'd12, 1'b1, 31'd1},
    '{31'd13,        ALT_B,  ALT_A,  1'b0, 31'd0},
    '{MODULUS_RESET, TOP63,  63'd1,  1'b0, 31'd0}
  };

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [BASE_BITS-1:0] base_value_i   = '0;
  logic [EXP_BITS-1:0]  exponent_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [MOD_BITS-1:0]  power_result_o;
  logic                 cfg_we_i       = 1'b0;
  logic [MOD_BITS-1:0]  cfg_wdata_i    = '0;

  // Expected powers in transfer order, and the modulus the block holds.
  logic [MOD_BITS-1:0] powers_due [$];
  logic [MOD_BITS-1:0] modulus_q = MODULUS_RESET;
  logic [MOD_BITS-1:0] head_power;

  int send_idle_pct = 8;
  int recv_idle_pct = 59;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  always #CLK_HALF_NS clk_i = ~clk_i;

  modular_exponentiation u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Right-to-left square-and-multiply; every operand stays below 2^31, so
  // each product fits in 64 bits. A zero modulus acts as one, and the
  // running product starts at one unreduced.
  function automatic logic [MOD_BITS-1:0] power_mod(input logic [BASE_BITS-1:0] base,
                                                    input logic [EXP_BITS-1:0]  expo,
                                                    input logic [MOD_BITS-1:0]  modulus);
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] acc;
    m   = (modulus == '0) ? 64'd1 : 64'(modulus);
    sq  = 64'(base) % m;
    acc = 64'd1;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (expo[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  // Mix full-width bases, small ones, near multiples of the modulus and the
  // two extremes.
  function automatic logic [BASE_BITS-1:0] pick_base(input logic [MOD_BITS-1:0] modulus);
    logic [63:0] raw;
    logic [63:0] m;
    raw = {$urandom(), $urandom()};
    m   = (modulus == '0) ? 64'd1 : 64'(modulus);
    case ($urandom_range(3))
      0:       return raw[BASE_BITS-1:0];
      1:       return BASE_BITS'($urandom_range(1000));
      2:       return BASE_BITS'(m * 64'($urandom_range(1, 32'h7FFF_FFFF))
                                 + 64'($urandom_range(2)) - 64'd1);
      default: return ($urandom_range(1) != 0) ? ALL63 : '0;
    endcase
  endfunction

  // Keep most exponents short so the run stays fast; a tenth span all bits.
  function automatic logic [EXP_BITS-1:0] pick_exponent();
    logic [63:0] raw;
    int unsigned roll;
    int unsigned len;
    raw  = {$urandom(), $urandom()};
    roll = $urandom_range(99);
    len  = $urandom_range(1, 12);
    if (roll < 5) return '0;
    if (roll < 15) return raw[EXP_BITS-1:0];
    return EXP_BITS'((raw & ((64'd1 << len) - 64'd1)) | (64'd1 << (len - 1)));
  endfunction

  // Offer one operand pair and hold it until the block takes it. Enter and
  // leave at a rising edge; valid stays high on return so back-to-back
  // transfers need no extra assignment.
  task automatic push_operands(input logic [BASE_BITS-1:0] base,
                               input logic [EXP_BITS-1:0]  expo,
                               input logic                 known,
                               input logic [MOD_BITS-1:0]  want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_value_i <= base;
    exponent_i   <= expo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    powers_due = {powers_due, (known ? want : power_mod(base, expo, modulus_q))};
  endtask

  // Drain every outstanding power, then write the modulus.
  task automatic set_modulus(input logic [MOD_BITS-1:0] modulus);
    in_valid_i <= 1'b0;
    while (powers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= modulus;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    modulus_q = modulus;
  endtask

  task automatic run_block(input logic [MOD_BITS-1:0] modulus, input int count);
    set_modulus(modulus);
    repeat (count) push_operands(pick_base(modulus_q), pick_exponent(), 1'b0, '0);
  endtask

  // Result side: check each transfer against the oldest expected power, then
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (powers_due.size() == 0) begin
        $error("power_result: expected none, actual %0d", power_result_o);
        mismatches++;
      end else begin
        head_power = powers_due.pop_front();
        if (power_result_o !== head_power) begin
          $error("power_result: expected %0d, actual %0d", head_power, power_result_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Stop a hung run: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: rewrite the modulus only where a row changes it.
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].modulus != modulus_q) set_modulus(DIRECTED_ROWS[r].modulus);
      push_operands(DIRECTED_ROWS[r].base, DIRECTED_ROWS[r].expo,
                    DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
    end

    // Random blocks: slow receiver first, then slow sender, then full rate.
    run_block(MOD_BITS'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)), BLOCK_ITEMS);
    run_block(MOD_BITS'($urandom_range(1, 64)), BLOCK_ITEMS);
    send_idle_pct = 59;
    recv_idle_pct = 8;
    run_block(MOD_MAX, BLOCK_ITEMS);
    run_block(MOD_BITS'($urandom_range(2, 65536)), BLOCK_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_block(MODULUS_RESET, BLOCK_ITEMS);
    run_block(MOD_BITS'($urandom_range(1, 32'h7FFF_FFFF)), BLOCK_ITEMS);

    // Drop valid, wait for the last powers, then watch for strays.
    in_valid_i <= 1'b0;
    while (powers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
